@@ rtl/core/llm_pkg.sv @@
// llm_pkg: operation and status codes and the store control bundle
// for the indexed linked list manager; no dependencies
`default_nettype none

package llm_pkg;

    // request operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PLACED    = 2'd1,
        ST_UNPLACED  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // store access strobes driven by the sequencer
    typedef struct packed {
        logic head_rd;
        logic head_we;
        logic next_rd;
        logic next_we;
        logic placed_set;
        logic placed_clr;
    } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/llm_store.sv @@
// llm_store: list head memory with valid bits, next link memory and placed flags
// depends on llm_pkg
`default_nettype none

module llm_store #(
    parameter int ENTITIES = 64,
    parameter int IW       = 6,
    parameter int PW       = 7
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire llm_pkg::mem_ctl_t ctl,
    input  wire  [IW-1:0]        head_addr,
    input  wire  [PW-1:0]        head_wdata,
    output logic [PW-1:0]        head_rdata,
    input  wire  [IW-1:0]        next_raddr,
    input  wire  [IW-1:0]        next_waddr,
    input  wire  [PW-1:0]        next_wdata,
    output logic [PW-1:0]        next_rdata,
    input  wire  [IW-1:0]        ent_addr,
    output logic                 placed
);
    import llm_pkg::*;

    logic [PW-1:0]       head_mem [ENTITIES];
    logic [PW-1:0]       next_mem [ENTITIES];
    logic [ENTITIES-1:0] head_valid_reg;
    logic [ENTITIES-1:0] placed_reg;
    logic [PW-1:0]       head_q_reg;
    logic                head_vq_reg;
    logic [PW-1:0]       next_q_reg;

    // head memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.head_we)
        begin
            head_mem[head_addr] <= head_wdata;
        end
        if (ctl.head_rd)
        begin
            head_q_reg <= head_mem[head_addr];
        end
    end

    // next link memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (ctl.next_rd)
        begin
            next_q_reg <= next_mem[next_raddr];
        end
    end

    // head valid bits and placed flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            placed_reg     <= '0;
            head_vq_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.head_we)
            begin
                head_valid_reg[head_addr] <= 1'b1;
            end
            if (ctl.head_rd)
            begin
                head_vq_reg <= head_valid_reg[head_addr];
            end
            if (ctl.placed_set)
            begin
                placed_reg[ent_addr] <= 1'b1;
            end
            else if (ctl.placed_clr)
            begin
                placed_reg[ent_addr] <= 1'b0;
            end
        end
    end

    // a head never written reads as the empty list mark
    assign head_rdata = head_vq_reg ? head_q_reg : PW'(ENTITIES);
    assign next_rdata = next_q_reg;
    assign placed     = placed_reg[ent_addr];

endmodule

`default_nettype wire

@@ rtl/core/indexed_linked_list_manager.sv @@
// Indexed linked list manager: add pushes an entity on a container list, remove
// walks the list one link per next-memory read. Add runs through check and head
// steps; remove through check, head, a walk and next pair per link visited, unlink
// and clear, paced by the single registered read port of the next link memory.
// One request at a time. Reset clears head valid bits and placed flags at once;
// no clearing pass. Result strobe done lasts one cycle; the receiver cannot stall.
`default_nettype none

module indexed_linked_list_manager #(
    parameter int ENTITIES = 64
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        operation,
    input  wire  [5:0] container_id,
    input  wire  [5:0] entity_id,
    output logic       done,
    output logic [1:0] status
);
    import llm_pkg::*;

    localparam int IW = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
    localparam int PW = $clog2(ENTITIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HEAD,
        S_WALK,
        S_NEXT,
        S_UNLINK,
        S_CLEAR
    } state_t;

    state_t        state_reg;
    logic          op_reg;
    logic [5:0]    cont_reg;
    logic [5:0]    ent_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] nxt_reg;
    logic [PW-1:0] steps_reg;
    logic          has_prev_reg;
    logic          done_reg;
    status_t       status_reg;

    mem_ctl_t      ctl;
    logic [IW-1:0] cont_idx;
    logic [IW-1:0] ent_idx;
    logic [PW-1:0] head_wdata;
    logic [PW-1:0] head_rdata;
    logic [IW-1:0] next_waddr;
    logic [PW-1:0] next_wdata;
    logic [PW-1:0] next_rdata;
    logic          placed;
    logic          ids_ok;
    logic          walk_end;
    logic          cur_hit;

    assign cont_idx = IW'(cont_reg);
    assign ent_idx  = IW'(ent_reg);
    assign ids_ok   = (32'(cont_reg) < ENTITIES) && (32'(ent_reg) < ENTITIES);
    assign walk_end = (steps_reg == PW'(ENTITIES)) || (cur_reg >= PW'(ENTITIES));
    assign cur_hit  = (cur_reg == PW'(ent_idx));

    llm_store #(
        .ENTITIES (ENTITIES),
        .IW       (IW),
        .PW       (PW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .head_addr  (cont_idx),
        .head_wdata (head_wdata),
        .head_rdata (head_rdata),
        .next_raddr (cur_reg[IW-1:0]),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .next_rdata (next_rdata),
        .ent_addr   (ent_idx),
        .placed     (placed)
    );

    // store strobes and write data per sequencer step
    always_comb
    begin
        ctl        = '0;
        head_wdata = PW'(ent_idx);
        next_waddr = ent_idx;
        next_wdata = head_rdata;
        unique case (state_reg)
            S_CHECK:
            begin
                ctl.head_rd = ids_ok && (placed == (op_reg == OP_REMOVE));
            end
            S_HEAD:
            begin
                if (op_reg == OP_ADD)
                begin
                    ctl.head_we    = 1'b1;
                    ctl.next_we    = 1'b1;
                    ctl.placed_set = 1'b1;
                end
            end
            S_WALK:
            begin
                ctl.next_rd = !walk_end;
            end
            S_UNLINK:
            begin
                head_wdata = nxt_reg;
                next_waddr = prev_reg[IW-1:0];
                next_wdata = nxt_reg;
                ctl.head_we = !has_prev_reg;
                ctl.next_we = has_prev_reg;
            end
            S_CLEAR:
            begin
                next_wdata     = PW'(ENTITIES);
                ctl.next_we    = 1'b1;
                ctl.placed_clr = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            status_reg   <= ST_DONE;
            op_reg       <= OP_ADD;
            cont_reg     <= '0;
            ent_reg      <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            nxt_reg      <= '0;
            steps_reg    <= '0;
            has_prev_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= operation;
                        cont_reg  <= container_id;
                        ent_reg   <= entity_id;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (op_reg == OP_ADD && (!ids_ok || placed))
                    begin
                        status_reg <= ST_PLACED;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (op_reg == OP_REMOVE && (!ids_ok || !placed))
                    begin
                        status_reg <= ST_UNPLACED;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        status_reg <= ST_DONE;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        cur_reg      <= head_rdata;
                        steps_reg    <= '0;
                        has_prev_reg <= 1'b0;
                        state_reg    <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (walk_end)
                    begin
                        status_reg <= ST_NOT_FOUND;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (cur_hit)
                    begin
                        nxt_reg   <= next_rdata;
                        state_reg <= S_UNLINK;
                    end
                    else
                    begin
                        prev_reg     <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cur_reg      <= next_rdata;
                        steps_reg    <= steps_reg + PW'(1);
                        state_reg    <= S_WALK;
                    end
                end
                S_UNLINK:
                begin
                    state_reg <= S_CLEAR;
                end
                S_CLEAR:
                begin
                    status_reg <= ST_DONE;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

`ifndef SYNTH
    // a transfer moves the sequencer out of idle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    // a result is only produced as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a request");

    // the walk never visits more links than there are entities
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= PW'(ENTITIES))
        else $error("list walk ran past its bound");

    // an add never reports a failed walk
    a_add_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg == OP_ADD) |-> (status_reg == ST_DONE || status_reg == ST_PLACED))
        else $error("add request gave a remove status");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for the indexed linked list manager
// depends on llm_pkg and indexed_linked_list_manager from rtl/core
`timescale 1ns / 1ps

module tb_top;
    import llm_pkg::*;

    localparam int N_ENT          = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_GAP        = 20;
    // long enough for the slowest remove, a walk over every entity
    localparam int DRAIN_CYCLES   = 5 + 2 * N_ENT + 8;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       operation;
    logic [5:0] container_id;
    logic [5:0] entity_id;
    logic       done;
    logic [1:0] status;

    // list state mirror and the queue of statuses still to come
    class list_tracker;
        logic [6:0] head_of [N_ENT];
        logic [6:0] link_of [N_ENT];
        bit         placed  [N_ENT];
        status_t    expected_q[$];
        int         errors;
        int         result_no;

        function new();
            for (int i = 0; i < N_ENT; i++)
            begin
                head_of[i] = 7'(N_ENT);
                link_of[i] = '0;
                placed[i]  = 1'b0;
            end
            errors    = 0;
            result_no = 0;
        endfunction

        // apply one request to the mirror and return its status
        function status_t apply(logic op, int c, int e);
            int cur;
            int prev;
            bit has_prev;
            if (c >= N_ENT || e >= N_ENT)
                return (op == OP_ADD) ? ST_PLACED : ST_UNPLACED;
            if (op == OP_ADD)
            begin
                if (placed[e])
                    return ST_PLACED;
                placed[e]  = 1'b1;
                link_of[e] = head_of[c];
                head_of[c] = 7'(e);
                return ST_DONE;
            end
            if (!placed[e])
                return ST_UNPLACED;
            // walk from the head, one link per step, bounded by the table size
            cur      = int'(head_of[c]);
            prev     = 0;
            has_prev = 1'b0;
            for (int steps = 0; steps < N_ENT && cur < N_ENT; steps++)
            begin
                if (cur == e)
                begin
                    if (has_prev)
                        link_of[prev] = link_of[cur];
                    else
                        head_of[c] = link_of[cur];
                    placed[cur]  = 1'b0;
                    link_of[cur] = 7'(N_ENT);
                    return ST_DONE;
                end
                prev     = cur;
                has_prev = 1'b1;
                cur      = int'(link_of[cur]);
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_request(logic op, logic [5:0] c, logic [5:0] e);
            expected_q.push_back(apply(op, int'(c), int'(e)));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_status(status_t got);
            status_t want;
            result_no++;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("result %0d: status %s with no request outstanding",
                                          result_no, got.name()));
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("result %0d: status %s, expected %s",
                                              result_no, got.name(), want.name()));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    list_tracker tracker;
    int          idle_pct;
    int          home [N_ENT];
    int          stall_cycles;

    indexed_linked_list_manager #(
        .ENTITIES(N_ENT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .container_id(container_id),
        .entity_id   (entity_id),
        .done        (done),
        .status      (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // monitor: check results, then note each accepted transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_status(status_t'(status));
            if (start && !busy)
                tracker.note_request(operation, container_id, entity_id);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // drive one request after a random gap and wait for its transfer
    task automatic issue(input logic op, input int c, input int e);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start        <= 1'b1;
        operation    <= op;
        container_id <= 6'(c);
        entity_id    <= 6'(e);
        do
            @(posedge clk);
        while (busy);
        // stimulus-side record of where each entity sits
        if (op == OP_ADD)
        begin
            if (home[e] < 0)
                home[e] = c;
        end
        else if (home[e] == c)
            home[e] = -1;
    endtask

    // hold off until every outstanding status has come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed adds and removes, some misdirected ones and noise
    task automatic random_item();
        int pick;
        int c;
        int e;
        int free_q[$];
        int used_q[$];
        pick = $urandom_range(99);
        c    = ($urandom_range(99) < 75) ? 21 * $urandom_range(3) : $urandom_range(63);
        for (int i = 0; i < N_ENT; i++)
        begin
            if (home[i] < 0)
                free_q.push_back(i);
            else
                used_q.push_back(i);
        end
        if (pick < 45 && free_q.size() > 0)
            issue(OP_ADD, c, free_q[$urandom_range(free_q.size() - 1)]);
        else if (pick < 85 && used_q.size() > 0)
        begin
            e = used_q[$urandom_range(used_q.size() - 1)];
            issue(OP_REMOVE, home[e], e);
        end
        else if (pick < 90 && used_q.size() > 0)
        begin
            // remove from a container that does not hold the entity
            e = used_q[$urandom_range(used_q.size() - 1)];
            issue(OP_REMOVE, (home[e] + 1 + $urandom_range(62)) % N_ENT, e);
        end
        else if (pick < 95 && used_q.size() > 0)
            issue(OP_ADD, c, used_q[$urandom_range(used_q.size() - 1)]);
        else
            issue(logic'($urandom_range(1)), $urandom_range(63), $urandom_range(63));
    endtask

    // pile every free entity onto one list, then take them off in random order
    task automatic sweep();
        int box;
        int k;
        int e;
        int members[$];
        box = $urandom_range(63);
        for (int i = 0; i < N_ENT; i++)
            if (home[i] < 0)
                members.push_back(i);
        while (members.size() > 0)
        begin
            k = $urandom_range(members.size() - 1);
            e = members[k];
            members.delete(k);
            issue(OP_ADD, box, e);
        end
        for (int i = 0; i < N_ENT; i++)
            if (home[i] == box)
                members.push_back(i);
        while (members.size() > 0)
        begin
            k = $urandom_range(members.size() - 1);
            e = members[k];
            members.delete(k);
            issue(OP_REMOVE, box, e);
        end
    endtask

    // main sequence
    initial
    begin
        int idle_plan [4];
        idle_plan    = '{0, 71, 0, 28};
        tracker      = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_ADD;
        container_id = '0;
        entity_id    = '0;
        idle_pct     = 0;
        for (int i = 0; i < N_ENT; i++)
            home[i] = -1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: unplaced remove, repeated add, wrong container
        issue(OP_REMOVE, 0, 0);
        issue(OP_ADD, 0, 0);
        issue(OP_ADD, 63, 0);
        issue(OP_ADD, 63, 63);
        issue(OP_ADD, 0, 63);
        issue(OP_REMOVE, 63, 0);
        // directed: head, middle and tail removal
        issue(OP_ADD, 0, 1);
        issue(OP_ADD, 0, 2);
        issue(OP_REMOVE, 0, 1);
        issue(OP_REMOVE, 0, 0);
        issue(OP_REMOVE, 0, 0);
        issue(OP_REMOVE, 0, 2);
        issue(OP_REMOVE, 63, 63);
        issue(OP_REMOVE, 63, 63);
        // directed: container holding itself, alternating bit patterns
        issue(OP_ADD, 42, 42);
        issue(OP_ADD, 42, 21);
        issue(OP_ADD, 21, 42);
        issue(OP_REMOVE, 21, 21);
        issue(OP_REMOVE, 42, 21);
        issue(OP_REMOVE, 42, 42);
        issue(OP_REMOVE, 42, 42);
        drain();

        // random phases, each ending with a full sweep and a pause
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            repeat (310) random_item();
            sweep();
            drain();
        end

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d statuses never arrived",
                                              tracker.pending()));
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
